FILE: rtl/core/lca_pkg.sv
// ----------------------------------------------------------------------------
// lca_pkg
// Shared types and constants of the lowest common ancestor engine.
// ----------------------------------------------------------------------------
package lca_pkg;

  localparam int ID_W     = 10;
  localparam int ID_COUNT = 1024;
  localparam int OPC_W    = 2;

  // Item opcodes
  localparam logic [OPC_W-1:0] OPC_CLEAR = 2'd0;
  localparam logic [OPC_W-1:0] OPC_EDGE  = 2'd1;
  localparam logic [OPC_W-1:0] OPC_QUERY = 2'd2;
  localparam logic [OPC_W-1:0] OPC_NONE  = 2'd3;

  // Datapath operations issued by the controller
  typedef logic [3:0] dp_op_t;
  localparam dp_op_t OP_NOP       = 4'd0;
  localparam dp_op_t OP_SWEEP     = 4'd1;
  localparam dp_op_t OP_EDGE_RD   = 4'd2;
  localparam dp_op_t OP_EDGE_WR   = 4'd3;
  localparam dp_op_t OP_LOAD_A    = 4'd4;
  localparam dp_op_t OP_STEP      = 4'd5;
  localparam dp_op_t OP_LOAD_B    = 4'd6;
  localparam dp_op_t OP_CMP_INIT  = 4'd7;
  localparam dp_op_t OP_CMP_STEP  = 4'd8;
  localparam dp_op_t OP_RES_HIT   = 4'd9;
  localparam dp_op_t OP_RES_MATCH = 4'd10;
  localparam dp_op_t OP_RES_ERR   = 4'd11;
  localparam dp_op_t OP_OUT       = 4'd12;

  typedef struct packed {
    dp_op_t op;
  } lca_cmd_t;

  typedef struct packed {
    logic has_parent;   // table entry of the current node has a parent
    logic walk_over;    // walk already made NODES steps
    logic walk_second;  // second node is being walked
    logic path_eq;      // path entries under compare are equal
    logic idx_zero;     // one of the compare indexes reached the start node
    logic cmp_first;    // compare is at the root entries
    logic sweep_last;   // clear sweep at the last table entry
    logic out_free;     // output register can take a result
  } lca_status_t;

endpackage

FILE: rtl/core/lca_if.sv
// ----------------------------------------------------------------------------
// lca_in_if / lca_out_if
// Valid/ready channels for items and results of the engine.
// ----------------------------------------------------------------------------
interface lca_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [9:0] node_a;
  logic [9:0] node_b;

  modport source (output valid, output opcode, output node_a, output node_b, input ready);
  modport sink   (input valid, input opcode, input node_a, input node_b, output ready);
endinterface

interface lca_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] ancestor;
  logic       cycle_error;

  modport source (output valid, output ancestor, output cycle_error, input ready);
  modport sink   (input valid, input ancestor, input cycle_error, output ready);
endinterface

FILE: rtl/core/lowest_common_ancestor_engine_top.sv
// ----------------------------------------------------------------------------
// lowest_common_ancestor_engine_top
// Parent table and lowest common ancestor search over a rooted forest.
// ----------------------------------------------------------------------------
// Items are taken one at a time. After reset the table is wiped, one entry a
// cycle, with item.ready low; a clear item runs the same sweep. An edge item
// does a table read, then a write if the child has no parent yet. In a query,
// each upward step is one registered read of the parent table, each downward
// compare step one read of both path memories, and the result then goes to
// the output register. A walk that still finds a parent after NODES steps
// ends with cycle_error set and ancestor at 0; nodes with different roots
// give no result. The next item is taken while a result waits in the output
// register.
// ----------------------------------------------------------------------------
module lowest_common_ancestor_engine_top #(
  parameter int NODES = 1024
) (
  input  logic      clk,
  input  logic      rst,
  lca_in_if.sink    item,
  lca_out_if.source result
);
  import lca_pkg::*;

  lca_cmd_t    cmd;
  lca_status_t status;

  // sequencer: owns item.ready and all step decisions
  lca_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item.valid),
    .item_opcode (item.opcode),
    .item_ready  (item.ready),
    .status      (status),
    .cmd         (cmd)
  );

  // table, path memories and output register
  lca_dp #(.NODES(NODES)) u_dp (
    .clk    (clk),
    .rst    (rst),
    .node_a (item.node_a),
    .node_b (item.node_b),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

  // reset always starts a table sweep
  a_sweep_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !item.ready)
    else $error("item taken during post-reset sweep");

  // a query keeps the engine busy past its accept cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready && item.opcode == OPC_QUERY |=> !item.ready)
    else $error("engine ready right after a query transfer");

  // an error result never carries an ancestor
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.cycle_error |-> result.ancestor == '0)
    else $error("cycle error result with nonzero ancestor");

  // a new result only appears as the datapath loads it
  a_out_from_cmd: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(cmd.op == OP_OUT))
    else $error("result valid without an output load");

endmodule

FILE: rtl/core/lca_ram.sv
// ----------------------------------------------------------------------------
// lca_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/lca_ctrl.sv
// ----------------------------------------------------------------------------
// lca_ctrl
// Sequencer: decodes items and steps the datapath through clear, edge and
// query work.
// ----------------------------------------------------------------------------
module lca_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  logic [1:0]            item_opcode,
  output logic                  item_ready,
  input  lca_pkg::lca_status_t  status,
  output lca_pkg::lca_cmd_t     cmd
);
  import lca_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EDGE   = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_CMP    = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0] state, state_next;
  logic       accept;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NOP;
    unique case (state)
      S_CLEAR: begin
        cmd.op = OP_SWEEP;
        if (status.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (item_opcode)
            OPC_CLEAR: state_next = S_CLEAR;
            OPC_EDGE: begin
              cmd.op     = OP_EDGE_RD;
              state_next = S_EDGE;
            end
            OPC_QUERY: begin
              cmd.op     = OP_LOAD_A;
              state_next = S_WALK;
            end
            OPC_NONE: state_next = S_IDLE;
          endcase
        end
      end
      S_EDGE: begin
        // first edge for a child wins
        if (!status.has_parent) begin
          cmd.op = OP_EDGE_WR;
        end
        state_next = S_IDLE;
      end
      S_WALK: begin
        priority if (!status.has_parent) begin
          if (status.walk_second) begin
            cmd.op     = OP_CMP_INIT;
            state_next = S_CMP;
          end else begin
            cmd.op = OP_LOAD_B;
          end
        end else if (status.walk_over) begin
          cmd.op     = OP_RES_ERR;
          state_next = S_RESULT;
        end else begin
          cmd.op = OP_STEP;
        end
      end
      S_CMP: begin
        priority if (!status.path_eq) begin
          if (status.cmp_first) begin
            state_next = S_IDLE;  // different roots: no answer
          end else begin
            cmd.op     = OP_RES_MATCH;
            state_next = S_RESULT;
          end
        end else if (status.idx_zero) begin
          cmd.op     = OP_RES_HIT;
          state_next = S_RESULT;
        end else begin
          cmd.op = OP_CMP_STEP;
        end
      end
      S_RESULT: begin
        if (status.out_free) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/core/lca_dp.sv
// ----------------------------------------------------------------------------
// lca_dp
// Datapath: parent table, the two path memories, walk and compare indexes,
// and the output register.
// ----------------------------------------------------------------------------
module lca_dp #(
  parameter int NODES = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [9:0]           node_a,
  input  logic [9:0]           node_b,
  input  lca_pkg::lca_cmd_t    cmd,
  output lca_pkg::lca_status_t status,
  lca_out_if.source            result
);
  import lca_pkg::*;

  localparam int PATH_D = NODES + 1;
  localparam int PW     = $clog2(PATH_D);
  localparam int LW     = $clog2(NODES + 2);
  localparam int TW     = $clog2(ID_COUNT);

  logic [ID_W-1:0] cur, cur_next, hold;
  logic [LW-1:0]   len, len1;
  logic            sel;
  logic [PW-1:0]   i, j, i_next, j_next;
  logic            first;
  logic [ID_W-1:0] match, res_anc;
  logic            res_err;
  logic [TW-1:0]   sweep;
  logic            out_valid;
  logic [ID_W-1:0] out_anc;
  logic            out_err;

  // parent table: {has_parent, parent_of}
  logic            tab_we;
  logic [TW-1:0]   tab_waddr;
  logic [ID_W:0]   tab_wdata, tab_rd;

  // path memories
  logic            pf_we, ps_we;
  logic [PW-1:0]   pw_addr;
  logic [ID_W-1:0] pf_rd, ps_rd;

  always_comb begin
    cur_next = cur;
    unique case (cmd.op)
      OP_EDGE_RD: cur_next = node_b;
      OP_LOAD_A:  cur_next = node_a;
      OP_STEP:    cur_next = tab_rd[ID_W-1:0];
      OP_LOAD_B:  cur_next = hold;
      default:    cur_next = cur;
    endcase
  end

  always_comb begin
    i_next = i;
    j_next = j;
    unique case (cmd.op)
      OP_CMP_INIT: begin
        i_next = PW'(len1 - LW'(1));
        j_next = PW'(len - LW'(1));
      end
      OP_CMP_STEP: begin
        i_next = i - PW'(1);
        j_next = j - PW'(1);
      end
      default: begin
        i_next = i;
        j_next = j;
      end
    endcase
  end

  assign tab_we    = (cmd.op == OP_SWEEP) || (cmd.op == OP_EDGE_WR);
  assign tab_waddr = (cmd.op == OP_SWEEP) ? sweep : TW'(cur);
  assign tab_wdata = (cmd.op == OP_SWEEP) ? '0 : {1'b1, hold};

  assign pf_we   = (cmd.op == OP_LOAD_A) || ((cmd.op == OP_STEP) && !sel);
  assign ps_we   = (cmd.op == OP_LOAD_B) || ((cmd.op == OP_STEP) && sel);
  assign pw_addr = (cmd.op == OP_STEP) ? PW'(len) : '0;

  lca_ram #(.WIDTH(ID_W + 1), .DEPTH(ID_COUNT)) u_table (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (TW'(cur_next)),
    .rdata (tab_rd)
  );

  lca_ram #(.WIDTH(ID_W), .DEPTH(PATH_D)) u_path_first (
    .clk   (clk),
    .we    (pf_we),
    .waddr (pw_addr),
    .wdata (cur_next),
    .raddr (i_next),
    .rdata (pf_rd)
  );

  lca_ram #(.WIDTH(ID_W), .DEPTH(PATH_D)) u_path_second (
    .clk   (clk),
    .we    (ps_we),
    .waddr (pw_addr),
    .wdata (cur_next),
    .raddr (j_next),
    .rdata (ps_rd)
  );

  always_ff @(posedge clk) begin
    cur <= cur_next;
    i   <= i_next;
    j   <= j_next;
    unique case (cmd.op)
      OP_EDGE_RD: hold <= node_a;
      OP_LOAD_A: begin
        hold <= node_b;
        len  <= LW'(1);
      end
      OP_STEP: len <= len + LW'(1);
      OP_LOAD_B: begin
        len1 <= len;
        len  <= LW'(1);
      end
      OP_CMP_INIT: first <= 1'b1;
      OP_CMP_STEP: begin
        first <= 1'b0;
        match <= pf_rd;
      end
      OP_RES_HIT: begin
        res_anc <= pf_rd;
        res_err <= 1'b0;
      end
      OP_RES_MATCH: begin
        res_anc <= match;
        res_err <= 1'b0;
      end
      OP_RES_ERR: begin
        res_anc <= '0;
        res_err <= 1'b1;
      end
      OP_OUT: begin
        out_anc <= res_anc;
        out_err <= res_err;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep     <= '0;
      sel       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_SWEEP) begin
        sweep <= sweep + TW'(1);
      end
      if (cmd.op == OP_LOAD_A) begin
        sel <= 1'b0;
      end else if (cmd.op == OP_LOAD_B) begin
        sel <= 1'b1;
      end
      if (cmd.op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.has_parent  = tab_rd[ID_W];
  assign status.walk_over   = (len > LW'(NODES));
  assign status.walk_second = sel;
  assign status.path_eq     = (pf_rd == ps_rd);
  assign status.idx_zero    = (i == '0) || (j == '0);
  assign status.cmp_first   = first;
  assign status.sweep_last  = (sweep == {TW{1'b1}});
  assign status.out_free    = !out_valid || result.ready;

  assign result.valid       = out_valid;
  assign result.ancestor    = out_anc;
  assign result.cycle_error = out_err;

endmodule
